FILE: design/swmsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmsc_pkg
// Shared widths and register codes of the sliding window max-sum counter.
// ----------------------------------------------------------------------------
package swmsc_pkg;

  localparam int unsigned SumW      = 26;
  localparam int unsigned CountW    = 32;
  localparam int unsigned LenCfgW   = 11;
  localparam int unsigned VisitW    = 16;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 88;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [0:0] RegWindowLen = 1'b0;

  localparam logic [LenCfgW-1:0] WindowLenReset = 11'd1;

endpackage

FILE: design/sliding_window_max_sum_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_max_sum_count
// Moving sum over the last window_len samples with best-sum and tie tracking.
// ----------------------------------------------------------------------------
// Channel   Direction  Word
// s_axis    in         tdata: visit_count; tlast: last_sample
// m_axis    out        tdata: window_full, window_sum, best_sum, best_count,
//                      best_is_zero; tlast: is_final
// apb       in/out     window_len at byte address 0
//
// One word is accepted every cycle unless m_axis_tready holds the pipeline;
// each word then passes delay line read, sum update, best update and output.
// The delay line is a single memory with one write and one read per cycle.
// Stages only advance into an empty or draining stage, so bubbles collapse
// and a full pipeline stalls only while m_axis_tready is low.
// Reset clears the sequence state and sets window_len to one; the delay line
// needs no clearing because only entries of the current sequence are read.
// ----------------------------------------------------------------------------
module sliding_window_max_sum_count
  import swmsc_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] visit_count
  input  logic [InTdataW-1:0]   s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] window_full, [26:1] window_sum, [52:27] best_sum, [84:53] best_count,
  // [85] best_is_zero, [87:86] zero
  output logic [OutTdataW-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready
);

  localparam int unsigned SmpW = (SAMPLE_BITS < VisitW) ? SAMPLE_BITS : VisitW;
  localparam int unsigned PtrW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned LenW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CmpW = (LenW > LenCfgW) ? LenW : LenCfgW;

  localparam logic [CmpW-1:0] WinMaxC  = CmpW'(WINDOW_MAX);
  localparam logic [PtrW-1:0] PtrLastC = PtrW'(WINDOW_MAX - 1);
  localparam logic [LenW-1:0] FillTopC = LenW'(WINDOW_MAX);

  logic [LenCfgW-1:0] window_len_q;

  logic [SmpW-1:0] mem [WINDOW_MAX];

  logic [PtrW-1:0] wp_q;
  logic [LenW-1:0] fill_q;
  logic [SumW-1:0] sum_q;
  logic [SumW-1:0] max_q;
  logic [CountW-1:0] cnt_q;

  logic            s1_vld_q;
  logic [SmpW-1:0] s1_rd_q;
  logic [SmpW-1:0] s1_smp_q;
  logic            s1_need_q;
  logic            s1_full_q;
  logic            s1_last_q;

  logic            s2_vld_q;
  logic [SumW-1:0] s2_sum_q;
  logic            s2_full_q;
  logic            s2_last_q;

  logic              out_vld_q;
  logic              out_full_q;
  logic [SumW-1:0]   out_sum_q;
  logic [SumW-1:0]   out_best_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_zero_q;
  logic              out_last_q;

  logic en_o;
  logic en_2;
  logic en_1;
  logic acc;
  logic cfg_wr;

  logic [SmpW-1:0] sample;
  logic [CmpW-1:0] len_raw;
  logic [CmpW-1:0] len_eff;
  logic [CmpW-1:0] fill_ext;
  logic [CmpW-1:0] wp_ext;
  logic [CmpW-1:0] rd_ext;
  logic [PtrW-1:0] rd_idx;
  logic [PtrW-1:0] wp_nxt;
  logic [LenW-1:0] fill_nxt;
  logic            need;
  logic            full0;

  logic [SumW-1:0] leave_ext;
  logic [SumW-1:0] sum_d;

  logic              take;
  logic              tie;
  logic [SumW-1:0]   max_d;
  logic [CountW-1:0] cnt_d;

  assign en_o          = !out_vld_q || m_axis_tready;
  assign en_2          = !s2_vld_q || en_o;
  assign en_1          = !s1_vld_q || en_2;
  assign s_axis_tready = en_1;
  assign acc           = s_axis_tvalid && en_1;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegWindowLen);

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegWindowLen) begin
      prdata = ApbDataW'(window_len_q);
    end
  end

  assign sample   = s_axis_tdata[SmpW-1:0];
  assign len_raw  = CmpW'(window_len_q);
  assign fill_ext = CmpW'(fill_q);
  assign wp_ext   = CmpW'(wp_q);

  always_comb begin
    len_eff = len_raw;
    if (len_raw == '0) begin
      len_eff = CmpW'(1);
    end else if (len_raw > WinMaxC) begin
      len_eff = WinMaxC;
    end
    need = fill_ext >= len_eff;
    if (wp_ext >= len_eff) begin
      rd_ext = wp_ext - len_eff;
    end else begin
      rd_ext = (WinMaxC - len_eff) + wp_ext;
    end
    rd_idx   = rd_ext[PtrW-1:0];
    wp_nxt   = (wp_q == PtrLastC) ? '0 : wp_q + PtrW'(1);
    fill_nxt = (fill_q < FillTopC) ? fill_q + LenW'(1) : fill_q;
    full0    = CmpW'(fill_nxt) >= len_eff;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem[wp_q] <= sample;
      s1_rd_q   <= mem[rd_idx];
      s1_smp_q  <= sample;
      s1_need_q <= need;
      s1_full_q <= full0;
      s1_last_q <= s_axis_tlast;
    end
  end

  assign leave_ext = s1_need_q ? SumW'(s1_rd_q) : '0;
  assign sum_d     = sum_q - leave_ext + SumW'(s1_smp_q);

  always_ff @(posedge clk_i) begin
    if (s1_vld_q && en_2) begin
      s2_sum_q  <= sum_d;
      s2_full_q <= s1_full_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    take  = s2_full_q && ((cnt_q == '0) || (s2_sum_q > max_q));
    tie   = s2_full_q && !take && (s2_sum_q == max_q);
    max_d = take ? s2_sum_q : max_q;
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = CountW'(1);
    end else if (tie && (cnt_q != '1)) begin
      cnt_d = cnt_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q && en_o) begin
      out_full_q <= s2_full_q;
      out_sum_q  <= s2_sum_q;
      out_best_q <= max_d;
      out_cnt_q  <= cnt_d;
      out_zero_q <= s2_full_q && (max_d == '0);
      out_last_q <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WindowLenReset;
      wp_q         <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      max_q        <= '0;
      cnt_q        <= '0;
      s1_vld_q     <= 1'b0;
      s2_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        window_len_q <= pwdata[LenCfgW-1:0];
      end
      if (acc) begin
        wp_q   <= s_axis_tlast ? '0 : wp_nxt;
        fill_q <= s_axis_tlast ? '0 : fill_nxt;
      end
      if (en_1) begin
        s1_vld_q <= acc;
      end
      if (en_2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (s1_vld_q && en_2) begin
        sum_q <= s1_last_q ? '0 : sum_d;
      end
      if (en_o) begin
        out_vld_q <= s2_vld_q;
      end
      if (s2_vld_q && en_o) begin
        max_q <= s2_last_q ? '0 : max_d;
        cnt_q <= s2_last_q ? '0 : cnt_d;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_zero_q, out_cnt_q, out_best_q, out_sum_q, out_full_q};

endmodule

FILE: tb/sv/tb_sliding_window_max_sum_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_max_sum_count
// Self-checking testbench for the sliding window max-sum counter.
// A local model keeps its own delay line, moving sum and best-sum tracking
// and predicts one result for every accepted word. Directed sequences cover
// the field extremes, zero and oversized window lengths, ties, all-zero
// windows, length changes in mid-sequence and a wrap of the moving sum. A
// long random phase follows, with random gaps on the input and random
// stalls on the output.
// ----------------------------------------------------------------------------
module tb_sliding_window_max_sum_count;
  import swmsc_pkg::*;

  localparam int unsigned HistDepth    = 1024;
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned RandomWords  = 350;
  localparam logic [ApbAddrW-1:0] WindowLenAddr = ApbAddrW'({RegWindowLen, 2'b00});
  localparam logic [ApbAddrW-1:0] SpareAddr     = ApbAddrW'(4);
  localparam logic [VisitW-1:0]   SampleTop     = '1;

  typedef enum int unsigned {MixTiny, MixZero, MixEdge, MixWide} sample_mix_e;

  typedef struct {
    logic              window_full;
    logic [SumW-1:0]   window_sum;
    logic [SumW-1:0]   best_sum;
    logic [CountW-1:0] best_count;
    logic              best_is_zero;
    logic              is_final;
  } window_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ApbAddrW-1:0]  paddr         = '0;
  logic [ApbDataW-1:0]  pwdata        = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  logic [VisitW-1:0]  hist_mem [HistDepth];
  logic [9:0]         hist_wp    = '0;
  int unsigned        hist_fill  = 0;
  logic [SumW-1:0]    acc_sum    = '0;
  logic [SumW-1:0]    peak_sum   = '0;
  logic [CountW-1:0]  peak_hits  = '0;
  logic [LenCfgW-1:0] len_reg    = WindowLenReset;

  window_result_t pending_results[$];
  window_result_t due_result;
  int unsigned    gap_max         = 14;
  int unsigned    stall_max       = 14;
  int unsigned    stall_left      = 0;
  int unsigned    errors          = 0;
  int unsigned    words_sent      = 0;
  int unsigned    results_checked = 0;
  int unsigned    len_writes      = 0;

  sliding_window_max_sum_count dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned window_span(input logic [LenCfgW-1:0] len);
    if (len == '0) return 1;
    if (len > HistDepth) return HistDepth;
    return len;
  endfunction

  function automatic window_result_t predict_window(input logic [VisitW-1:0] sample,
                                                    input logic last);
    window_result_t res;
    int unsigned    span;
    logic [VisitW-1:0] leaving;
    logic [9:0]     old_idx;
    span    = window_span(len_reg);
    leaving = '0;
    if (hist_fill >= span) begin
      old_idx = hist_wp - 10'(span);
      leaving = hist_mem[old_idx];
    end
    acc_sum = acc_sum - SumW'(leaving) + SumW'(sample);
    hist_mem[hist_wp] = sample;
    hist_wp = hist_wp + 10'd1;
    if (hist_fill < HistDepth) hist_fill++;
    res.window_full = (hist_fill >= span);
    if (res.window_full) begin
      if (peak_hits == '0 || acc_sum > peak_sum) begin
        peak_sum  = acc_sum;
        peak_hits = 1;
      end else if (acc_sum == peak_sum && peak_hits != '1) begin
        peak_hits = peak_hits + 1;
      end
    end
    res.window_sum   = acc_sum;
    res.best_sum     = peak_sum;
    res.best_count   = peak_hits;
    res.best_is_zero = res.window_full && (peak_sum == '0);
    res.is_final     = last;
    if (last) begin
      hist_wp   = '0;
      hist_fill = 0;
      acc_sum   = '0;
      peak_sum  = '0;
      peak_hits = '0;
    end
    return res;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic logic [VisitW-1:0] draw_sample(input sample_mix_e mix);
    case (mix)
      MixZero: return '0;
      MixTiny: return VisitW'($urandom_range(3, 0));
      MixEdge: return ($urandom_range(1, 0) != 0) ? SampleTop : VisitW'($urandom_range(1, 0));
      default: return VisitW'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, actual tdata %0h", $time, m_axis_tdata);
        errors++;
      end else begin
        due_result = pending_results.pop_front();
        check_field("window_full", due_result.window_full, m_axis_tdata[0]);
        check_field("window_sum", due_result.window_sum, m_axis_tdata[26:1]);
        check_field("best_sum", due_result.best_sum, m_axis_tdata[52:27]);
        check_field("best_count", due_result.best_count, m_axis_tdata[84:53]);
        check_field("best_is_zero", due_result.best_is_zero, m_axis_tdata[85]);
        check_field("is_final", due_result.is_final, m_axis_tlast);
        results_checked++;
      end
      stall_left = $urandom_range(stall_max, 0);
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [VisitW-1:0] sample, input logic last);
    int unsigned gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_window(sample, last));
    words_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ApbAddrW-1:0] addr,
                          input logic [ApbDataW-1:0] wdata,
                          output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_window_len(input logic [LenCfgW-1:0] len);
    logic [ApbDataW-1:0] rd;
    wait_drained();
    apb_xfer(1'b1, WindowLenAddr, ApbDataW'(len), rd);
    len_reg = len;
    len_writes++;
    apb_xfer(1'b0, WindowLenAddr, '0, rd);
    check_field("window_len readback", len, rd);
  endtask

  task automatic test_reset_defaults();
    logic [ApbDataW-1:0] rd;
    apb_xfer(1'b0, WindowLenAddr, '0, rd);
    check_field("window_len after reset", WindowLenReset, rd);
  endtask

  // Directed cases; the first uses a window of one: a new maximum, a smaller sum, then a tie.
  task automatic test_directed_cases();
    logic [ApbDataW-1:0] rd;
    send_sample(SampleTop, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SampleTop, 1'b0);
    send_sample('0, 1'b1);

    write_window_len('0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    send_sample('0, 1'b1);

    write_window_len(11'd3);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    write_window_len(11'd5);
    send_sample(16'd7, 1'b0);
    send_sample(16'd7, 1'b0);
    write_window_len(11'd2);
    send_sample(16'd9, 1'b0);
    send_sample(16'd9, 1'b1);

    // A write outside the register map must leave window_len alone.
    wait_drained();
    apb_xfer(1'b1, SpareAddr, $urandom, rd);
    apb_xfer(1'b0, WindowLenAddr, '0, rd);
    check_field("window_len after unmapped write", len_reg, rd);

    write_window_len(11'h7FF);
    send_sample(SampleTop, 1'b0);
    send_sample(16'd1, 1'b1);

    write_window_len(11'd1);
    send_sample(16'h8000, 1'b1);
  endtask

  // Full 1024-word window of top samples, then a shrink and regrowth of the
  // window so that the moving sum wraps.
  task automatic test_full_window_wrap();
    gap_max   = 0;
    stall_max = 0;
    write_window_len(11'd1024);
    repeat (HistDepth) send_sample(SampleTop, 1'b0);
    gap_max   = 14;
    stall_max = 14;
    write_window_len(11'd1);
    send_sample('0, 1'b0);
    send_sample('0, 1'b0);
    write_window_len(11'd2);
    send_sample(SampleTop, 1'b0);
    send_sample(SampleTop, 1'b0);
    send_sample(VisitW'($urandom), 1'b0);
    send_sample(VisitW'($urandom), 1'b1);
  endtask

  task automatic test_random_sequences();
    int unsigned       start_words;
    int unsigned       pick;
    int unsigned       span;
    int unsigned       seq_words;
    logic [LenCfgW-1:0] new_len;
    sample_mix_e       mix;
    logic              flag;
    logic [VisitW-1:0] sample;
    start_words = words_sent;
    while (words_sent - start_words < RandomWords) begin
      pick = $urandom_range(19, 0);
      if (pick == 0) new_len = '0;
      else if (pick == 1) new_len = 11'h7FF;
      else if (pick == 2) new_len = LenCfgW'($urandom_range(2047, 65));
      else if (pick < 6) new_len = LenCfgW'($urandom_range(64, 9));
      else new_len = LenCfgW'($urandom_range(8, 1));
      write_window_len(new_len);
      gap_max   = ($urandom_range(3, 0) == 0) ? 0 : 14;
      stall_max = ($urandom_range(3, 0) == 0) ? 0 : 14;
      mix       = sample_mix_e'($urandom_range(3, 0));
      span      = window_span(new_len);
      seq_words = (span > 64) ? $urandom_range(12, 1) : $urandom_range(4 * span + 8, 1);
      for (int i = 0; i < seq_words; i++) begin
        if (i == seq_words - 1) flag = ($urandom_range(4, 0) != 0);
        else flag = ($urandom_range(40, 0) == 0);
        sample = ($urandom_range(15, 0) == 0) ? VisitW'($urandom) : draw_sample(mix);
        send_sample(sample, flag);
      end
      if ($urandom_range(7, 0) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_cases();
    test_full_window_wrap();
    test_random_sequences();
    wait_drained();
    $display("Sent %0d samples and checked %0d results across %0d window length writes,",
             words_sent, results_checked, len_writes);
    $display("including ties, all-zero windows, mid-sequence length changes and a sum wrap.");
    if (errors == 0) begin
      $display("sliding_window_max_sum_count test passed");
    end else begin
      $display("sliding_window_max_sum_count test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("sliding_window_max_sum_count test failed");
    $finish;
  end

endmodule

FILE: sim.f
design/swmsc_pkg.sv
design/sliding_window_max_sum_count.sv
tb/sv/tb_sliding_window_max_sum_count.sv
